/* sv/buffered_delta_switch_element_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the buffered delta switch element
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef BUFFERED_DELTA_SWITCH_ELEMENT_UNIT_ASSERT_SVH
`define BUFFERED_DELTA_SWITCH_ELEMENT_UNIT_ASSERT_SVH

// property must hold in the same cycle
`define BDSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property must hold in the following cycle
`define BDSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bdse_pkg.sv */
// ----------------------------------------------------------------------------
// bdse_pkg
// Constants, types and the routing digit function of the switch element.
// ----------------------------------------------------------------------------
package bdse_pkg;

   localparam int IN_PORTS    = 2;
   localparam int OUT_PORTS   = 2;
   localparam int BUF_DEPTH   = 4;
   localparam int TAG_BITS    = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int IN_IDX_W  = $clog2(IN_PORTS);
   localparam int OUT_IDX_W = $clog2(OUT_PORTS);
   localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_W   = 7;
   localparam bit OUT_POW2  = (OUT_PORTS & (OUT_PORTS - 1)) == 0;

   localparam logic [OUT_IDX_W-1:0] OUT_LAST = OUT_IDX_W'(OUT_PORTS - 1);

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_TICK    = 1'b1
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      port_ok;
      logic [IN_IDX_W-1:0]       port;
      logic [TAG_BITS-1:0]       tag;
      logic [OUT_PORTS-1:0]      mask;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // base-OUT_PORTS digit of tag at position pos
   function automatic logic [OUT_IDX_W-1:0] steer_digit(
      input logic [TAG_BITS-1:0] tag,
      input logic [2:0]          pos
   );
      logic [TAG_BITS-1:0] d;
      d = tag;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < pos) begin
            if (OUT_POW2) begin
               d = d >> OUT_IDX_W;
            end else begin
               d = TAG_BITS'(d / OUT_PORTS);
            end
         end
      end
      return OUT_IDX_W'(d % OUT_PORTS);
   endfunction

endpackage

/* sv/bdse_front.sv */
// ----------------------------------------------------------------------------
// bdse_front
// Accepts requests and decodes them into queue entries.
// ----------------------------------------------------------------------------
module bdse_front
   import bdse_pkg::*;
(
   input  logic         start,
   output logic         busy,
   input  logic         req_command,
   input  logic [2:0]   req_in_port,
   input  logic [7:0]   req_dest_tag,
   input  logic [7:0]   req_blocked_mask,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    entry
);

   assign busy = q_status.full;
   assign push = start && !q_status.full;

   always_comb begin
      entry.kind    = req_command ? CMD_TICK : CMD_ENQUEUE;
      entry.port_ok = int'(req_in_port) < IN_PORTS;
      entry.port    = req_in_port[IN_IDX_W-1:0];
      entry.tag     = req_dest_tag[TAG_BITS-1:0];
      entry.mask    = req_blocked_mask[OUT_PORTS-1:0];
   end

endmodule

/* sv/bdse_queue.sv */
// ----------------------------------------------------------------------------
// bdse_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module bdse_queue
   import bdse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head_entry,
   output q_status_type q_status
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_status.empty = count_ff == '0;
   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_entry     = entries_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_entry;
      end
   end

endmodule

/* sv/bdse_back.sv */
// ----------------------------------------------------------------------------
// bdse_back
// Input FIFOs, output arbitration and result sequencing.
// ----------------------------------------------------------------------------
`include "buffered_delta_switch_element_unit_assert.svh"

module bdse_back
   import bdse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_write_data,
   input  q_status_type q_status,
   input  entry_type    entry,
   output logic         pop,
   output logic         rsp_valid,
   output logic [2:0]   rsp_out_port,
   output logic         rsp_packet_valid,
   output logic [7:0]   rsp_packet_dest,
   output logic [2:0]   rsp_source_port,
   output logic [6:0]   rsp_waiting_total,
   output logic         rsp_enqueue_accepted,
   output logic         rsp_last
);

   bk_state_type          state_ff, state_in;
   logic [2:0]            digit_pos_ff;
   logic [TAG_BITS-1:0]   store_ff [IN_PORTS][BUF_DEPTH];
   logic [PTR_W-1:0]      rd_ff   [IN_PORTS];
   logic [PTR_W-1:0]      rd_in   [IN_PORTS];
   logic [PTR_W-1:0]      wr_ff   [IN_PORTS];
   logic [PTR_W-1:0]      wr_in   [IN_PORTS];
   logic [CNT_W-1:0]      fill_ff [IN_PORTS];
   logic [CNT_W-1:0]      fill_in [IN_PORTS];
   logic [OUT_IDX_W-1:0]  emit_idx_ff, emit_idx_in;

   logic                  res_v_ff    [OUT_PORTS];
   logic [TAG_BITS-1:0]   res_dest_ff [OUT_PORTS];
   logic [IN_IDX_W-1:0]   res_src_ff  [OUT_PORTS];
   logic [TOTAL_W-1:0]    total_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_out_port_ff, rsp_out_port_in;
   logic                  rsp_pkt_v_ff, rsp_pkt_v_in;
   logic [7:0]            rsp_dest_ff, rsp_dest_in;
   logic [2:0]            rsp_src_ff, rsp_src_in;
   logic [6:0]            rsp_total_ff, rsp_total_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  deq, do_enq, do_tick, emitting, enq_ok;
   logic [TAG_BITS-1:0]   head     [IN_PORTS];
   logic                  req_v    [IN_PORTS];
   logic [OUT_IDX_W-1:0]  digit    [IN_PORTS];
   logic                  pop_port [IN_PORTS];
   logic                  gnt_v    [OUT_PORTS];
   logic [IN_IDX_W-1:0]   gnt_src  [OUT_PORTS];
   logic [TAG_BITS-1:0]   gnt_dest [OUT_PORTS];
   logic [TOTAL_W-1:0]    total;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty && entry.kind == CMD_TICK) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (emit_idx_ff == OUT_LAST) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      deq      = 1'b0;
      emitting = 1'b0;
      case (state_ff)
         BK_IDLE: deq      = !q_status.empty;
         BK_EMIT: emitting = 1'b1;
         default: ;
      endcase
   end

   assign pop     = deq;
   assign do_enq  = deq && entry.kind == CMD_ENQUEUE;
   assign do_tick = deq && entry.kind == CMD_TICK;
   assign enq_ok  = do_enq && entry.port_ok && fill_ff[entry.port] < CNT_W'(BUF_DEPTH);

   // request and grant
   always_comb begin
      total = '0;
      for (int i = 0; i < IN_PORTS; i++) begin
         head[i]  = store_ff[i][rd_ff[i]];
         req_v[i] = fill_ff[i] != '0;
         digit[i] = steer_digit(head[i], digit_pos_ff);
         total    = total + TOTAL_W'(fill_ff[i]);
      end
      for (int o = 0; o < OUT_PORTS; o++) begin
         gnt_v[o]   = 1'b0;
         gnt_src[o] = '0;
         for (int i = IN_PORTS - 1; i >= 0; i--) begin
            if (req_v[i] && digit[i] == OUT_IDX_W'(o) && !entry.mask[o]) begin
               gnt_v[o]   = 1'b1;
               gnt_src[o] = IN_IDX_W'(i);
            end
         end
         gnt_dest[o] = gnt_v[o] ? head[gnt_src[o]] : '0;
      end
      for (int i = 0; i < IN_PORTS; i++) begin
         pop_port[i] = 1'b0;
         for (int o = 0; o < OUT_PORTS; o++) begin
            if (gnt_v[o] && gnt_src[o] == IN_IDX_W'(i)) begin
               pop_port[i] = 1'b1;
            end
         end
      end
   end

   // FIFO pointers and fill counts
   always_comb begin
      for (int i = 0; i < IN_PORTS; i++) begin
         rd_in[i]   = rd_ff[i];
         wr_in[i]   = wr_ff[i];
         fill_in[i] = fill_ff[i];
         if (enq_ok && entry.port == IN_IDX_W'(i)) begin
            wr_in[i]   = (wr_ff[i] == PTR_W'(BUF_DEPTH - 1)) ? '0 : wr_ff[i] + 1'b1;
            fill_in[i] = fill_ff[i] + 1'b1;
         end
         if (do_tick && pop_port[i]) begin
            rd_in[i]   = (rd_ff[i] == PTR_W'(BUF_DEPTH - 1)) ? '0 : rd_ff[i] + 1'b1;
            fill_in[i] = fill_ff[i] - 1'b1;
         end
      end
   end

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (do_tick) begin
         emit_idx_in = '0;
      end else if (emitting) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   // response payload
   always_comb begin
      rsp_valid_in    = do_enq || emitting;
      rsp_out_port_in = '0;
      rsp_pkt_v_in    = 1'b0;
      rsp_dest_in     = '0;
      rsp_src_in      = '0;
      rsp_total_in    = '0;
      rsp_acc_in      = 1'b0;
      rsp_last_in     = 1'b0;
      if (do_enq) begin
         rsp_acc_in  = enq_ok;
         rsp_last_in = 1'b1;
      end
      if (emitting) begin
         rsp_out_port_in = 3'(emit_idx_ff);
         rsp_pkt_v_in    = res_v_ff[emit_idx_ff];
         rsp_dest_in     = 8'(res_dest_ff[emit_idx_ff]);
         rsp_src_in      = 3'(res_src_ff[emit_idx_ff]);
         rsp_total_in    = total_ff;
         rsp_last_in     = emit_idx_ff == OUT_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         digit_pos_ff <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < IN_PORTS; i++) begin
            rd_ff[i]   <= '0;
            wr_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            digit_pos_ff <= csr_write_data;
         end
         for (int i = 0; i < IN_PORTS; i++) begin
            rd_ff[i]   <= rd_in[i];
            wr_ff[i]   <= wr_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         store_ff[entry.port][wr_ff[entry.port]] <= entry.tag;
      end
      if (do_tick) begin
         total_ff <= total;
         for (int o = 0; o < OUT_PORTS; o++) begin
            res_v_ff[o]    <= gnt_v[o];
            res_dest_ff[o] <= gnt_dest[o];
            res_src_ff[o]  <= gnt_src[o];
         end
      end
      rsp_out_port_ff <= rsp_out_port_in;
      rsp_pkt_v_ff    <= rsp_pkt_v_in;
      rsp_dest_ff     <= rsp_dest_in;
      rsp_src_ff      <= rsp_src_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_acc_ff      <= rsp_acc_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_port         = rsp_out_port_ff;
   assign rsp_packet_valid     = rsp_pkt_v_ff;
   assign rsp_packet_dest      = rsp_dest_ff;
   assign rsp_source_port      = rsp_src_ff;
   assign rsp_waiting_total    = rsp_total_ff;
   assign rsp_enqueue_accepted = rsp_acc_ff;
   assign rsp_last             = rsp_last_ff;

   for (genvar g = 0; g < IN_PORTS; g++) begin : g_fill_chk
      `BDSE_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff[g] <= CNT_W'(BUF_DEPTH), "fill count above depth")
      `BDSE_ASSERT_NEXT(a_fill_hold, clock, reset, state_ff == BK_EMIT, $stable(fill_ff[g]), "FIFO changed while emitting")
   end

   `BDSE_ASSERT_NEXT(a_emit_strobe, clock, reset, state_ff == BK_EMIT, rsp_valid_ff, "missing tick response")
   `BDSE_ASSERT_NEXT(a_emit_last, clock, reset, state_ff == BK_EMIT && emit_idx_ff == OUT_LAST, rsp_last_ff && rsp_valid_ff, "tick not closed by last")

endmodule

/* sv/buffered_delta_switch_element_unit.sv */
// ----------------------------------------------------------------------------
// buffered_delta_switch_element_unit
// One switching element of a multibuffered delta network with per-input FIFOs.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   req_*                        start & !busy
//  response  rsp_*                        rsp_valid, one cycle, no stall
//  csr       csr_write_enable/_write_data write on enable
//
//  Enqueue: response the cycle after the back end pops the entry from the queue.
//  Tick: grants are registered, then one response per output is emitted in turn.
//  A two-entry request queue decouples decode from execution; busy = queue full.
//  Synchronous reset empties FIFOs and the queue, digit position 0.
//  Responses cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module buffered_delta_switch_element_unit
   import bdse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_command,
   input  logic [2:0] req_in_port,
   input  logic [7:0] req_dest_tag,
   input  logic [7:0] req_blocked_mask,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   output logic       rsp_valid,
   output logic [2:0] rsp_out_port,
   output logic       rsp_packet_valid,
   output logic [7:0] rsp_packet_dest,
   output logic [2:0] rsp_source_port,
   output logic [6:0] rsp_waiting_total,
   output logic       rsp_enqueue_accepted,
   output logic       rsp_last
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head_entry;

   bdse_front u_front (
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_in_port      (req_in_port),
      .req_dest_tag     (req_dest_tag),
      .req_blocked_mask (req_blocked_mask),
      .q_status         (q_status),
      .push             (push),
      .entry            (push_entry)
   );

   bdse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   bdse_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .q_status             (q_status),
      .entry                (head_entry),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_out_port         (rsp_out_port),
      .rsp_packet_valid     (rsp_packet_valid),
      .rsp_packet_dest      (rsp_packet_dest),
      .rsp_source_port      (rsp_source_port),
      .rsp_waiting_total    (rsp_waiting_total),
      .rsp_enqueue_accepted (rsp_enqueue_accepted),
      .rsp_last             (rsp_last)
   );

endmodule
